### rtl/msq_pkg.sv
package msq_pkg;

  localparam int unsigned StepsDefault = 8;
  localparam int unsigned TickW        = 5;
  localparam int unsigned NoteW        = 8;

  localparam logic [TickW-1:0] TicksReset  = 5'd12;
  localparam logic [NoteW-1:0] NoteDefault = 8'd60;

  typedef enum logic [7:0] {
    MidiClock    = 8'd248,
    MidiStart    = 8'd250,
    MidiContinue = 8'd251,
    MidiStop     = 8'd252
  } midi_rt_e;

  // Per-item decisions from the control stage, carried to the note stage.
  typedef struct packed {
    logic       preview;
    logic       nav_note;
    logic       play_fire;
    logic       edit_en;
    logic       edit_down;
    logic [7:0] led_pattern;
    logic [2:0] play_pos;
    logic [2:0] cursor_pos;
    logic       running;
  } ctrl_t;

endpackage

### rtl/midi_clock_step_sequencer.sv
// A result passes through the note stage register and then the output register.
// Throughput: one item per cycle while m_axis_tready keeps the output draining; the note
// memory reads in the accept cycle and the edited note is written back when the item
// leaves the note stage, with forwarding.
// Reset (rst_ni low, asynchronous): positions and tick count zero, running (not halted), gates and
// LEDs dark, ticks_per_step 12, every step note 60 through the memory's valid bits.
module midi_clock_step_sequencer #(
  parameter int unsigned STEPS = msq_pkg::StepsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [msq_pkg::TickW-1:0] cfg_wdata_i,     // ticks_per_step
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [0] next_prev_level, [1] set_level, [2] note_level, [3] func_level,
  // [4] byte_valid, [12:5] midi_byte, [15:13] zero
  input  logic [15:0]               s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] preview_valid, [1] note_valid, [9:2] note_number, [17:10] led_pattern,
  // [20:18] play_position, [23:21] cursor_position, [24] running, [31:25] zero
  output logic [31:0]               m_axis_tdata
);
  import msq_pkg::*;

  localparam int unsigned SW = $clog2(STEPS);

  ctrl_t            ctrl, s1_info_q;
  logic [SW-1:0]    edit_addr, play_addr, s1_addr_a_q, s1_addr_b_q, fwd_addr_q;
  logic [NoteW-1:0] rd_a, rd_b, base_a, base_b, edit_val, play_note, fwd_data_q;
  logic [NoteW-1:0] note_num;
  logic             s1_valid_q, out_valid_q, fwd_valid_q;
  logic             in_xfer, s1_adv, wr_en;
  logic [31:0]      out_data_q;

  // Advance the note stage whenever the output register is free or draining.
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  msq_ctrl #(.STEPS(STEPS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_en_i    (in_xfer),
    .nav_i        (s_axis_tdata[0]),
    .set_i        (s_axis_tdata[1]),
    .note_i       (s_axis_tdata[2]),
    .func_i       (s_axis_tdata[3]),
    .byte_valid_i (s_axis_tdata[4]),
    .midi_byte_i  (s_axis_tdata[12:5]),
    .ctrl_o       (ctrl),
    .edit_addr_o  (edit_addr),
    .play_addr_o  (play_addr)
  );

  msq_note_mem #(.STEPS(STEPS)) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_xfer),
    .rd_addr_a_i (edit_addr),
    .rd_addr_b_i (play_addr),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .wr_en_i     (wr_en),
    .wr_addr_i   (s1_addr_a_q),
    .wr_data_i   (edit_val)
  );

  // A write landing on the same edge as the read is missed by the memory:
  // take it from the forward register instead.
  assign base_a = (fwd_valid_q && fwd_addr_q == s1_addr_a_q) ? fwd_data_q : rd_a;
  assign base_b = (fwd_valid_q && fwd_addr_q == s1_addr_b_q) ? fwd_data_q : rd_b;

  assign edit_val  = s1_info_q.edit_down ? base_a - 1'b1 : base_a + 1'b1;
  // The edit comes before the played step within one item.
  assign play_note = (s1_info_q.edit_en && s1_addr_a_q == s1_addr_b_q) ? edit_val : base_b;
  assign wr_en     = s1_valid_q && s1_adv && s1_info_q.edit_en;

  always_comb begin
    if (s1_info_q.play_fire) begin
      note_num = play_note;
    end else if (s1_info_q.nav_note) begin
      note_num = NoteDefault;
    end else begin
      note_num = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_info_q   <= ctrl;
      s1_addr_a_q <= edit_addr;
      s1_addr_b_q <= play_addr;
      fwd_addr_q  <= s1_addr_a_q;
      fwd_data_q  <= edit_val;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= {7'b0, s1_info_q.running, s1_info_q.cursor_pos, s1_info_q.play_pos,
                     s1_info_q.led_pattern, note_num,
                     s1_info_q.play_fire || s1_info_q.nav_note, s1_info_q.preview};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        fwd_valid_q <= wr_en;
      end
      if (s_axis_tready) begin
        s1_valid_q <= in_xfer;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_wr_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_valid_q && s1_info_q.edit_en) else $error("note write without item");
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && wr_en |=> fwd_valid_q) else $error("forward lost for same-edge write");
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_a_q))
    else $error("note stage dropped a stalled item");

endmodule

### rtl/msq_note_mem.sv
module msq_note_mem #(
  parameter int unsigned STEPS = msq_pkg::StepsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(STEPS)-1:0]   rd_addr_a_i,
  input  logic [$clog2(STEPS)-1:0]   rd_addr_b_i,
  output logic [msq_pkg::NoteW-1:0]  rd_data_a_o,
  output logic [msq_pkg::NoteW-1:0]  rd_data_b_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(STEPS)-1:0]   wr_addr_i,
  input  logic [msq_pkg::NoteW-1:0]  wr_data_i
);
  import msq_pkg::*;

  logic [NoteW-1:0] mem [STEPS];
  logic [STEPS-1:0] vld_q;
  logic [NoteW-1:0] rd_a_q, rd_b_q;
  logic             rd_vld_a_q, rd_vld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  // Unwritten entries read as the default note.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_vld_a_q <= 1'b0;
      rd_vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_a_q <= vld_q[rd_addr_a_i];
        rd_vld_b_q <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = rd_vld_a_q ? rd_a_q : NoteDefault;
  assign rd_data_b_o = rd_vld_b_q ? rd_b_q : NoteDefault;

endmodule

### rtl/msq_ctrl.sv
module msq_ctrl #(
  parameter int unsigned STEPS = msq_pkg::StepsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [msq_pkg::TickW-1:0]  cfg_wdata_i,
  input  logic                       item_en_i,
  input  logic                       nav_i,
  input  logic                       set_i,
  input  logic                       note_i,
  input  logic                       func_i,
  input  logic                       byte_valid_i,
  input  logic [7:0]                 midi_byte_i,
  output msq_pkg::ctrl_t             ctrl_o,
  output logic [$clog2(STEPS)-1:0]   edit_addr_o,
  output logic [$clog2(STEPS)-1:0]   play_addr_o
);
  import msq_pkg::*;

  localparam int unsigned SW = $clog2(STEPS);
  localparam logic [SW-1:0] Last = SW'(STEPS - 1);

  logic [TickW-1:0] tps_q;
  logic [SW-1:0]    cursor_q, cursor_d, play_q, play_d, nxt_play, new_cursor;
  logic [TickW-1:0] tick_q, tick_d, tick_inc;
  logic             halted_q, halted_d;
  logic [STEPS-1:0] gate_q, gate_d, led_q, led_d;
  logic             note_held_q, set_held_q, nav_held_q;
  logic             note_press, set_press, nav_press;
  logic             preview, nav_note, play_fire;
  logic [STEPS+7:0] led_ext;
  logic [SW+2:0]    play_ext, cursor_ext;

  assign note_press = note_i && !note_held_q;
  assign set_press  = set_i && !set_held_q;
  assign nav_press  = nav_i && !nav_held_q;
  assign tick_inc   = tick_q + 1'b1;
  assign nxt_play   = (play_q >= Last) ? '0 : play_q + 1'b1;

  always_comb begin
    if (func_i) begin
      new_cursor = (cursor_q == '0) ? Last : cursor_q - 1'b1;
    end else begin
      new_cursor = (cursor_q >= Last) ? '0 : cursor_q + 1'b1;
    end
  end

  // Buttons first (set, then navigation), then the MIDI byte.
  always_comb begin
    gate_d    = gate_q;
    led_d     = led_q;
    cursor_d  = cursor_q;
    play_d    = play_q;
    tick_d    = tick_q;
    halted_d  = halted_q;
    preview   = 1'b0;
    nav_note  = 1'b0;
    play_fire = 1'b0;
    if (set_press && !func_i) begin
      gate_d[cursor_q] = !gate_q[cursor_q];
      preview          = halted_q;
    end
    if (nav_press) begin
      cursor_d        = new_cursor;
      led_d[cursor_q] = gate_d[cursor_q];
      nav_note        = gate_d[new_cursor] && halted_q;
    end
    if (byte_valid_i) begin
      case (midi_byte_i)
        MidiStart: begin
          play_d   = '0;
          halted_d = 1'b0;
        end
        MidiStop: begin
          halted_d = 1'b1;
          led_d[0] = 1'b1;
          if (!gate_d[play_q]) begin
            led_d[play_q] = 1'b0;
          end
          play_d = '0;
          tick_d = '0;
        end
        MidiContinue: begin
          halted_d = 1'b0;
        end
        MidiClock: begin
          if (!halted_q) begin
            if (tick_inc == tps_q) begin
              play_d          = nxt_play;
              led_d[nxt_play] = 1'b1;
              if (!gate_d[play_q]) begin
                led_d[play_q] = 1'b0;
              end
              play_fire = gate_d[nxt_play];
              tick_d    = '0;
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= TicksReset;
      cursor_q    <= '0;
      play_q      <= '0;
      tick_q      <= '0;
      halted_q    <= 1'b0;
      gate_q      <= '0;
      led_q       <= '0;
      note_held_q <= 1'b0;
      set_held_q  <= 1'b0;
      nav_held_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (item_en_i) begin
        cursor_q    <= cursor_d;
        play_q      <= play_d;
        tick_q      <= tick_d;
        halted_q    <= halted_d;
        gate_q      <= gate_d;
        led_q       <= led_d;
        note_held_q <= note_i;
        set_held_q  <= set_i;
        nav_held_q  <= nav_i;
      end
    end
  end

  assign led_ext    = {8'b0, led_d};
  assign play_ext   = {3'b0, play_d};
  assign cursor_ext = {3'b0, cursor_d};

  always_comb begin
    ctrl_o.preview     = preview;
    ctrl_o.nav_note    = nav_note;
    ctrl_o.play_fire   = play_fire;
    ctrl_o.edit_en     = note_press;
    ctrl_o.edit_down   = func_i;
    ctrl_o.led_pattern = led_ext[7:0];
    ctrl_o.play_pos    = play_ext[2:0];
    ctrl_o.cursor_pos  = cursor_ext[2:0];
    ctrl_o.running     = !halted_d;
  end

  assign edit_addr_o = cursor_q;
  assign play_addr_o = play_d;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= Last) else $error("cursor beyond last step");
  a_play_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_q <= Last) else $error("play step beyond last step");
  a_halt_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> tick_q == '0) else $error("tick count moved while halted");

endmodule

### tb/tb_midi_clock_step_sequencer.sv
`timescale 1ns / 100ps

module tb_midi_clock_step_sequencer;
  import msq_pkg::*;

  // Cycles without any transfer on either side before the run is given up.
  localparam int unsigned QuietLimit     = 1000;
  // Receiver hold-off at the start of each random phase, long enough to fill the block.
  localparam int unsigned HoldOffCycles  = 80;
  localparam int unsigned ItemsPerPhase  = 175;
  localparam int unsigned NumPhases      = 6;
  // Idle cycles after the last result before a register write or the final verdict.
  localparam int unsigned SettleCycles   = 6;

  typedef struct packed {
    logic [15:0] item;
    logic        typed;   // 1: result below is fixed, 0: take the predictor's
    logic [31:0] result;
  } directed_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [4:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  midi_clock_step_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Sequencer state as the testbench expects it to be.
  logic [4:0]  seq_ticks_per_step;
  logic [2:0]  seq_play;
  logic [2:0]  seq_cursor;
  logic [4:0]  seq_tick_count;
  logic        seq_halted;
  logic [7:0]  seq_gates;
  logic [7:0]  seq_leds;
  logic [7:0]  seq_notes [8];
  logic        seq_note_held;
  logic        seq_set_held;
  logic        seq_nav_held;

  logic [31:0] pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Both sides draw idle cycles only while this is set.
  bit idle_enable = 1'b1;
  // Ask the receiver for one long hold-off.
  bit hold_off_req = 1'b0;

  // Button levels of the random stimulus; they toggle now and then so that
  // presses, holds and releases all occur.
  logic lvl_nav, lvl_set, lvl_note, lvl_func;

  // Pack one input transfer: [0] nav, [1] set, [2] note, [3] func,
  // [4] byte_valid, [12:5] midi_byte.
  function automatic logic [15:0] make_item(logic nav, logic set, logic note, logic func,
                                            logic bvalid, logic [7:0] mbyte);
    return {3'b000, mbyte, bvalid, func, note, set, nav};
  endfunction

  function automatic directed_row_t plain_row(logic [15:0] item);
    return '{item: item, typed: 1'b0, result: '0};
  endfunction

  // Advance the expected sequencer state by one input item and return the
  // packed result that the block must send for it.
  function automatic logic [31:0] sequencer_next(logic [15:0] item);
    logic       nav, set, note, func, bvalid;
    logic [7:0] mbyte;
    logic       preview, nvalid;
    logic [7:0] nnum;
    logic [2:0] old_cursor, prev_play;
    nav     = item[0];
    set     = item[1];
    note    = item[2];
    func    = item[3];
    bvalid  = item[4];
    mbyte   = item[12:5];
    preview = 1'b0;
    nvalid  = 1'b0;
    nnum    = '0;

    // Buttons act on a press edge only, in the order note, set, navigation.
    if (note && !seq_note_held) begin
      seq_notes[seq_cursor] = func ? seq_notes[seq_cursor] - 8'd1
                                   : seq_notes[seq_cursor] + 8'd1;
      seq_note_held = 1'b1;
    end
    if (!note) seq_note_held = 1'b0;

    if (set && !seq_set_held) begin
      // With func held this is the slide press: only arm the held flag.
      if (!func) begin
        if (seq_halted) preview = 1'b1;
        seq_gates[seq_cursor] = ~seq_gates[seq_cursor];
      end
      seq_set_held = 1'b1;
    end
    if (!set) seq_set_held = 1'b0;

    if (nav && !seq_nav_held) begin
      old_cursor = seq_cursor;
      seq_cursor = func ? old_cursor - 3'd1 : old_cursor + 3'd1;
      // The step left behind shows its gate.
      seq_leds[old_cursor] = seq_gates[old_cursor];
      if (seq_gates[seq_cursor] && seq_halted) begin
        nvalid = 1'b1;
        nnum   = NoteDefault;
      end
      seq_nav_held = 1'b1;
    end
    if (!nav) seq_nav_held = 1'b0;

    if (bvalid) begin
      case (mbyte)
        MidiStart: begin
          // Start keeps the tick count.
          seq_play   = '0;
          seq_halted = 1'b0;
        end
        MidiStop: begin
          seq_halted  = 1'b1;
          seq_leds[0] = 1'b1;
          if (!seq_gates[seq_play]) seq_leds[seq_play] = 1'b0;
          seq_play       = '0;
          seq_tick_count = '0;
        end
        MidiContinue: begin
          seq_halted = 1'b0;
        end
        MidiClock: begin
          if (!seq_halted) begin
            // Five-bit counter: a setting of zero acts as 32 ticks.
            seq_tick_count = seq_tick_count + 5'd1;
            if (seq_tick_count == seq_ticks_per_step) begin
              prev_play          = seq_play;
              seq_play           = prev_play + 3'd1;
              seq_leds[seq_play] = 1'b1;
              if (!seq_gates[prev_play]) seq_leds[prev_play] = 1'b0;
              if (seq_gates[seq_play]) begin
                nvalid = 1'b1;
                nnum   = seq_notes[seq_play];
              end
              seq_tick_count = '0;
            end
          end
        end
        default: ;
      endcase
    end

    return {7'd0, ~seq_halted, seq_cursor, seq_play, seq_leds, nnum, nvalid, preview};
  endfunction

  // Draw one random item: mostly clock ticks and run-state bytes, with
  // absent bytes and raw noise mixed in.
  function automatic logic [15:0] random_item();
    int unsigned pick;
    logic        bvalid;
    logic [7:0]  mbyte;
    if ($urandom_range(0, 3) == 0) lvl_nav  = ~lvl_nav;
    if ($urandom_range(0, 3) == 0) lvl_set  = ~lvl_set;
    if ($urandom_range(0, 3) == 0) lvl_note = ~lvl_note;
    if ($urandom_range(0, 5) == 0) lvl_func = ~lvl_func;
    pick   = $urandom_range(0, 99);
    bvalid = 1'b1;
    mbyte  = 8'($urandom_range(0, 255));
    if (pick < 55)      mbyte = MidiClock;
    else if (pick < 59) mbyte = MidiStop;
    else if (pick < 62) mbyte = MidiStart;
    else if (pick < 65) mbyte = MidiContinue;
    else if (pick < 80) bvalid = 1'b0;
    else                bvalid = 1'($urandom_range(0, 1));
    return make_item(lvl_nav, lvl_set, lvl_note, lvl_func, bvalid, mbyte);
  endfunction

  // Offer one item after a random gap, hold it until the transfer and
  // record what the block must answer. Entered and left at a falling edge.
  task automatic send_item(input logic [15:0] item, input logic typed,
                           input logic [31:0] typed_result);
    int unsigned gap;
    logic [31:0] predicted;
    gap = idle_enable ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = sequencer_next(item);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  // Write ticks_per_step once the block has drained.
  task automatic write_ticks(input logic [4:0] value);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i           <= 1'b0;
    seq_ticks_per_step  = value;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: wait a random number of cycles before each transfer, and hold
  // off for a long stretch whenever the stimulus asks for it.
  initial begin : result_sink
    int unsigned wait_cycles;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      wait_cycles = idle_enable ? $urandom_range(0, 4) : 0;
      if (wait_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare every result transfer with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer 0x%08h with no result expected", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("preview_valid",   32'(want[0]),     32'(m_axis_tdata[0]));
        check_field("note_valid",      32'(want[1]),     32'(m_axis_tdata[1]));
        check_field("note_number",     32'(want[9:2]),   32'(m_axis_tdata[9:2]));
        check_field("led_pattern",     32'(want[17:10]), 32'(m_axis_tdata[17:10]));
        check_field("play_position",   32'(want[20:18]), 32'(m_axis_tdata[20:18]));
        check_field("cursor_position", 32'(want[23:21]), 32'(m_axis_tdata[23:21]));
        check_field("running",         32'(want[24]),    32'(m_axis_tdata[24]));
        check_field("padding",         32'(want[31:25]), 32'(m_axis_tdata[31:25]));
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_midi_clock_step_sequencer NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0]  ticks;
    logic [2:0]  sweep_step;
    // Reset values of the expected state.
    seq_ticks_per_step = TicksReset;
    seq_play           = '0;
    seq_cursor         = '0;
    seq_tick_count     = '0;
    seq_halted         = 1'b0;
    seq_gates          = '0;
    seq_leds           = '0;
    seq_note_held      = 1'b0;
    seq_set_held       = 1'b0;
    seq_nav_held       = 1'b0;
    foreach (seq_notes[i]) seq_notes[i] = NoteDefault;
    lvl_nav  = 1'b0;
    lvl_set  = 1'b0;
    lvl_note = 1'b0;
    lvl_func = 1'b0;

    // Directed part, run at the reset setting of 12 ticks per step.
    // Fresh after reset, nothing changes on idle items or ignored bytes.
    directed_rows.push_back('{make_item(0, 0, 0, 0, 0, 8'h00), 1'b1, 32'h0100_0000});
    directed_rows.push_back('{make_item(0, 0, 0, 0, 0, 8'hFF), 1'b1, 32'h0100_0000});
    directed_rows.push_back('{make_item(0, 0, 0, 0, 1, 8'h00), 1'b1, 32'h0100_0000});
    // Note up, held, released; note down with func.
    directed_rows.push_back(plain_row(make_item(0, 0, 1, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 1, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 1, 1, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    // Gate toggle while running (no preview), then a slide press.
    directed_rows.push_back(plain_row(make_item(0, 1, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 1, 0, 1, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    // Cursor next, then prev back onto the gated step while running.
    directed_rows.push_back(plain_row(make_item(1, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(1, 0, 0, 1, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    // Stop: step 0 lit, sequencer halted.
    directed_rows.push_back('{make_item(0, 0, 0, 0, 1, MidiStop), 1'b1, 32'h0000_0400});
    // While stopped: move, set preview, prev onto a gated step plays the default note.
    directed_rows.push_back(plain_row(make_item(1, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 1, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(1, 0, 0, 1, 0, 8'h00)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 0, 8'h00)));
    // Clock while halted is ignored; then continue and start.
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 1, MidiClock)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 1, MidiContinue)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 1, MidiStart)));
    // Every button at once with a tick, then all released with an unknown byte.
    directed_rows.push_back(plain_row(make_item(1, 1, 1, 1, 1, MidiClock)));
    directed_rows.push_back(plain_row(make_item(0, 0, 0, 0, 1, 8'hFF)));

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    // Random phases, each at its own tick setting: one tick, the 24 of full
    // speed, the 5-bit top, zero (acts as 32), a random one and two.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       ticks = 5'd1;
        1:       ticks = 5'd24;
        2:       ticks = 5'd31;
        3:       ticks = 5'd0;
        4:       ticks = 5'($urandom_range(1, 24));
        default: ticks = 5'd2;
      endcase
      // Drop the tvalid of the previous phase, then drain and write.
      s_axis_tvalid <= 1'b0;
      write_ticks(ticks);
      // One phase runs back to back on both sides.
      idle_enable  = (ph != 3);
      hold_off_req = 1'b1;

      if (ph == 0) begin
        // Sweep one step's note down past zero and back up past 255.
        sweep_step = seq_cursor;
        for (int n = 0; n < 90; n++) begin
          send_item(make_item(0, 0, 1, (n < 70), 0, 8'h00), 1'b0, '0);
          send_item(make_item(0, 0, 0, (n < 70), 1, MidiClock), 1'b0, '0);
        end
        lvl_note = 1'b0;
        lvl_func = 1'b0;
        // Arm the swept step so its wrapped note gets played.
        if (!seq_gates[sweep_step]) begin
          send_item(make_item(0, 1, 0, 0, 0, 8'h00), 1'b0, '0);
          send_item(make_item(0, 0, 0, 0, 0, 8'h00), 1'b0, '0);
        end
        lvl_set = 1'b0;
      end

      for (int n = 0; n < ItemsPerPhase; n++)
        send_item(random_item(), 1'b0, '0);
    end

    // Drain, let the pipeline settle, then report.
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_midi_clock_step_sequencer OK");
    end else begin
      $display("tb_midi_clock_step_sequencer NOT OK");
    end
    $finish;
  end

endmodule
